[rtl/lpce_pkg.sv]
`timescale 1ns / 1ps

package lpce_pkg;

    localparam int VAL_W     = 16;
    localparam int COUNT_W   = 11;
    localparam int INDEX_W   = 10;
    localparam int COLOR_W   = 24;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 32;
    localparam int MAX_PIXELS = 1024;

    localparam logic [VAL_W:0] COUNTER_MODULUS = 17'd65535;

    localparam logic [VAL_W-1:0]   RESET_START_OFFSET = 16'd14400;
    localparam logic [VAL_W-1:0]   RESET_BIT_PERIOD   = 16'd90;
    localparam logic [VAL_W-1:0]   RESET_ONE_HIGH     = 16'd58;
    localparam logic [VAL_W-1:0]   RESET_ONE_LOW      = 16'd32;
    localparam logic [VAL_W-1:0]   RESET_ZERO_HIGH    = 16'd29;
    localparam logic [VAL_W-1:0]   RESET_ZERO_LOW     = 16'd61;
    localparam logic [COUNT_W-1:0] RESET_PIXEL_COUNT  = 11'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_OFFSET = 3'd0,
        REG_BIT_PERIOD   = 3'd1,
        REG_ONE_HIGH     = 3'd2,
        REG_ONE_LOW      = 3'd3,
        REG_ZERO_HIGH    = 3'd4,
        REG_ZERO_LOW     = 3'd5,
        REG_PIXEL_COUNT  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [VAL_W-1:0]   start_offset;
        logic [VAL_W-1:0]   bit_period;
        logic [VAL_W-1:0]   one_high_time;
        logic [VAL_W-1:0]   one_low_time;
        logic [VAL_W-1:0]   zero_high_time;
        logic [VAL_W-1:0]   zero_low_time;
        logic [COUNT_W-1:0] pixel_count;
    } cfg_t;

    typedef struct packed {
        logic [VAL_W-1:0]   base;
        logic [COLOR_W-1:0] grb;
        logic               last_pixel;
    } work_t;

    // Reduces a sum below twice the modulus into the range of the counter.
    function automatic logic [VAL_W-1:0] mod_reduce(input logic [VAL_W:0] x);
        logic [VAL_W:0] r;
        begin
            r = (x >= COUNTER_MODULUS) ? (x - COUNTER_MODULUS) : x;
            return r[VAL_W-1:0];
        end
    endfunction

endpackage

[rtl/lpce_pixel_if.sv]
`timescale 1ns / 1ps

interface lpce_pixel_if import lpce_pkg::*;;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] color;

    modport source (output valid, output pixel_index, output color, input ready);
    modport sink (input valid, input pixel_index, input color, output ready);
endinterface

[rtl/lpce_code_if.sv]
`timescale 1ns / 1ps

interface lpce_code_if import lpce_pkg::*;;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] first_edge;
    logic [VAL_W-1:0] second_edge;
    logic             second_valid;
    logic             last;

    modport source (output valid, output first_edge, output second_edge,
                    output second_valid, output last, input ready);
    modport sink (input valid, input first_edge, input second_edge,
                  input second_valid, input last, output ready);
endinterface

[rtl/lpce_front.sv]
`timescale 1ns / 1ps

module lpce_front import lpce_pkg::*; #(
    parameter int BITS_PER_PIXEL = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    lpce_pixel_if.sink   pixels,
    output logic         work_valid,
    input  logic         work_ready,
    output work_t        work
);

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic               s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next;
    logic               adv1, adv2, adv3, adv4;

    logic [PROD_W-1:0]  s1_prod_reg, s1_prod_next;
    logic [PROD_W-1:0]  s2_prod_reg, s2_prod_next;
    logic [VAL_W-1:0]   s3_rem_reg, s3_rem_next;
    logic [VAL_W-1:0]   s4_base_reg, s4_base_next;

    logic [COLOR_W-1:0] s1_grb_reg, s2_grb_reg, s3_grb_reg, s4_grb_reg;
    logic               s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;
    logic [COLOR_W-1:0] grb_next;
    logic               last_next;

    logic [COUNT_W-1:0] count;
    logic [VAL_W:0]     fold;
    logic [VAL_W-1:0]   fold_red;

    assign adv4 = !s4_valid_reg || work_ready;
    assign adv3 = !s3_valid_reg || adv4;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;

    assign pixels.ready = adv1;

    always_comb
    begin
        count = (cfg.pixel_count > COUNT_W'(MAX_PIXELS)) ? COUNT_W'(MAX_PIXELS)
                                                         : cfg.pixel_count;
        last_next = (count != '0) &&
                    ({1'b0, pixels.pixel_index} == (count - COUNT_W'(1)));
        grb_next = {pixels.color[15:8], pixels.color[23:16], pixels.color[7:0]};
        s1_prod_next = PROD_W'(pixels.pixel_index) * PROD_W'(cfg.bit_period);
        s2_prod_next = s1_prod_reg * PROD_W'(BITS_PER_PIXEL);

        // Since 2^16 is one more than the modulus, the upper half folds onto the lower.
        fold = {1'b0, s2_prod_reg[PROD_W-1:VAL_W]} + {1'b0, s2_prod_reg[VAL_W-1:0]};
        fold_red = mod_reduce(fold);
        s3_rem_next = ({1'b0, fold_red} == COUNTER_MODULUS) ? '0 : fold_red;
        s4_base_next = mod_reduce({1'b0, s3_rem_reg} + {1'b0, cfg.start_offset});

        s1_valid_next = adv1 ? pixels.valid : s1_valid_reg;
        s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = adv3 ? s2_valid_reg : s3_valid_reg;
        s4_valid_next = adv4 ? s3_valid_reg : s4_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_grb_reg  <= grb_next;
            s1_last_reg <= last_next;
        end
        if (adv2)
        begin
            s2_prod_reg <= s2_prod_next;
            s2_grb_reg  <= s1_grb_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (adv3)
        begin
            s3_rem_reg  <= s3_rem_next;
            s3_grb_reg  <= s2_grb_reg;
            s3_last_reg <= s2_last_reg;
        end
        if (adv4)
        begin
            s4_base_reg <= s4_base_next;
            s4_grb_reg  <= s3_grb_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    assign work_valid      = s4_valid_reg;
    assign work.base       = s4_base_reg;
    assign work.grb        = s4_grb_reg;
    assign work.last_pixel = s4_last_reg;

endmodule

[rtl/lpce_queue.sv]
`timescale 1ns / 1ps

module lpce_queue import lpce_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  work_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output work_t pop_data
);

    work_t       mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/lpce_back.sv]
`timescale 1ns / 1ps

module lpce_back import lpce_pkg::*; #(
    parameter int BITS_PER_PIXEL = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         work_valid,
    output logic         work_ready,
    input  work_t        work,
    lpce_code_if.source  codes
);

    localparam int CNT_W = $clog2(BITS_PER_PIXEL);
    localparam int EXT_W = (BITS_PER_PIXEL > COLOR_W) ? BITS_PER_PIXEL : COLOR_W;

    logic                      busy_reg, busy_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [BITS_PER_PIXEL-1:0] shift_reg, shift_next;
    logic [VAL_W-1:0]          base_reg, base_next;
    logic                      last_pixel_reg, last_pixel_next;
    logic [VAL_W-1:0]          one_total_reg, zero_total_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]          first_reg, first_next;
    logic [VAL_W-1:0]          second_reg, second_next;
    logic                      second_valid_reg, second_valid_next;
    logic                      last_reg, last_next;

    logic                      out_free, emit, final_bit, load, bit_one;
    logic [VAL_W-1:0]          high_time, total_time;
    logic [EXT_W-1:0]          grb_ext;

    assign out_free   = !out_valid_reg || codes.ready;
    assign emit       = busy_reg && out_free;
    assign final_bit  = (cnt_reg == CNT_W'(BITS_PER_PIXEL - 1));
    assign work_ready = !busy_reg || (emit && final_bit);
    assign load       = work_valid && work_ready;

    assign bit_one    = shift_reg[BITS_PER_PIXEL-1];
    assign high_time  = bit_one ? cfg.one_high_time : cfg.zero_high_time;
    assign total_time = bit_one ? one_total_reg : zero_total_reg;
    assign grb_ext    = EXT_W'(work.grb);

    always_comb
    begin
        busy_next       = busy_reg;
        cnt_next        = cnt_reg;
        shift_next      = shift_reg;
        base_next       = base_reg;
        last_pixel_next = last_pixel_reg;
        if (emit)
        begin
            cnt_next   = cnt_reg + CNT_W'(1);
            shift_next = shift_reg << 1;
            base_next  = mod_reduce({1'b0, base_reg} + {1'b0, cfg.bit_period});
            if (final_bit)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next       = 1'b1;
            cnt_next        = '0;
            shift_next      = grb_ext[BITS_PER_PIXEL-1:0];
            base_next       = work.base;
            last_pixel_next = work.last_pixel;
        end
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        first_next        = first_reg;
        second_next       = second_reg;
        second_valid_next = second_valid_reg;
        last_next         = last_reg;
        if (emit)
        begin
            out_valid_next    = 1'b1;
            first_next        = mod_reduce({1'b0, base_reg} + {1'b0, high_time});
            second_valid_next = !(final_bit && last_pixel_reg);
            second_next       = (final_bit && last_pixel_reg) ? '0
                                : mod_reduce({1'b0, base_reg} + {1'b0, total_time});
            last_next         = final_bit;
        end
        else if (codes.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg          <= cnt_next;
        shift_reg        <= shift_next;
        base_reg         <= base_next;
        last_pixel_reg   <= last_pixel_next;
        first_reg        <= first_next;
        second_reg       <= second_next;
        second_valid_reg <= second_valid_next;
        last_reg         <= last_next;
        one_total_reg    <= mod_reduce({1'b0, cfg.one_high_time} + {1'b0, cfg.one_low_time});
        zero_total_reg   <= mod_reduce({1'b0, cfg.zero_high_time} + {1'b0, cfg.zero_low_time});
    end

    assign codes.valid        = out_valid_reg;
    assign codes.first_edge   = first_reg;
    assign codes.second_edge  = second_reg;
    assign codes.second_valid = second_valid_reg;
    assign codes.last         = last_reg;

endmodule

[rtl/led_pixel_compare_encoder.sv]
`timescale 1ns / 1ps

// Encodes LED pixels into pairs of timer compare values, one pair per color bit.
// The pixels channel takes one request per pixel: its index in the strip and an
// RGB color. The codes channel returns BITS_PER_PIXEL requests per pixel, GRB
// order, most significant bit first; the final one of each pixel has last set.
// Timing registers are written through the plain write port. The user must write
// them only while the block is idle; the block itself does not enforce this.
// The first code of a pixel passes the four front stages, the queue, the sequencer
// and the output register. The bit sequencer emits one code per cycle while the
// output register is free, and loads the next pixel as it emits the final code of
// the current one. A four-stage front computes each pixel's start count and a two-entry
// queue holds finished pixels, so new pixels are taken while the sequencer works.
// When the receiver stalls, the output register holds its code and the sequencer
// waits; the queue and front then fill before the pixels channel deasserts ready.
// Reset empties the pipeline and the queue and loads the default timing.

module led_pixel_compare_encoder import lpce_pkg::*; #(
    parameter int BITS_PER_PIXEL = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_data,
    lpce_pixel_if.sink           pixels,
    lpce_code_if.source          codes
);

    cfg_t  cfg_reg, cfg_next;
    logic  fw_valid, fw_ready, bw_valid, bw_ready;
    work_t fw_data, bw_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_START_OFFSET: cfg_next.start_offset   = cfg_data;
                REG_BIT_PERIOD:   cfg_next.bit_period     = cfg_data;
                REG_ONE_HIGH:     cfg_next.one_high_time  = cfg_data;
                REG_ONE_LOW:      cfg_next.one_low_time   = cfg_data;
                REG_ZERO_HIGH:    cfg_next.zero_high_time = cfg_data;
                REG_ZERO_LOW:     cfg_next.zero_low_time  = cfg_data;
                REG_PIXEL_COUNT:  cfg_next.pixel_count    = cfg_data[COUNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_offset   <= RESET_START_OFFSET;
            cfg_reg.bit_period     <= RESET_BIT_PERIOD;
            cfg_reg.one_high_time  <= RESET_ONE_HIGH;
            cfg_reg.one_low_time   <= RESET_ONE_LOW;
            cfg_reg.zero_high_time <= RESET_ZERO_HIGH;
            cfg_reg.zero_low_time  <= RESET_ZERO_LOW;
            cfg_reg.pixel_count    <= RESET_PIXEL_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lpce_front #(
        .BITS_PER_PIXEL (BITS_PER_PIXEL)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pixels     (pixels),
        .work_valid (fw_valid),
        .work_ready (fw_ready),
        .work       (fw_data)
    );

    lpce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fw_valid),
        .push_ready (fw_ready),
        .push_data  (fw_data),
        .pop_valid  (bw_valid),
        .pop_ready  (bw_ready),
        .pop_data   (bw_data)
    );

    lpce_back #(
        .BITS_PER_PIXEL (BITS_PER_PIXEL)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .work_valid (bw_valid),
        .work_ready (bw_ready),
        .work       (bw_data),
        .codes      (codes)
    );

endmodule
